### rtl/qssd_pkg.sv
package qssd_pkg;

    // operation codes carried in the input tuser
    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_BUTTON = 2'd1,
        OP_TICK   = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_QUEUED    = 3'd0,
        ST_ZERO      = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_FULL      = 3'd3,
        ST_NONE      = 3'd4
    } status_t;

    localparam int VALUE_W    = 20;
    localparam int DIGITS     = 6;
    localparam int SEG_W      = 8;
    localparam int STOP_BIT   = 0;
    localparam logic [31:0] MAX_NUMBER = 32'd999999;

    // floor(n / 10) == (n * DIV10_RECIP) >> DIV10_SHIFT for any 20-bit n
    localparam logic [VALUE_W-1:0] DIV10_RECIP = 20'd838861;
    localparam int DIV10_SHIFT = 23;

    // decimal digit to segment byte, gfedcba
    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

### rtl/qssd_ram.sv
module qssd_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/qssd_conv.sv
module qssd_conv (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          start,
    input  logic [qssd_pkg::VALUE_W-1:0]                  value,
    output logic                                          done,
    output logic [qssd_pkg::DIGITS*qssd_pkg::SEG_W-1:0]   seg
);
    import qssd_pkg::*;

    localparam int SEGS_W = DIGITS * SEG_W;
    localparam int CNT_W  = $clog2(DIGITS);

    logic [VALUE_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [SEGS_W-1:0]    seg_reg;
    logic [2*VALUE_W-1:0] product;
    logic [VALUE_W-1:0]   times_ten;
    logic [VALUE_W-1:0]   rem_full;

    // one decimal digit per cycle: divide by ten through the reciprocal
    always_comb
    begin
        product   = n_reg * DIV10_RECIP;
        n_next    = VALUE_W'(product[2*VALUE_W-1:DIV10_SHIFT]);
        times_ten = (n_next << 3) + (n_next << 1);
        rem_full  = n_reg - times_ten;
    end

    // digit loop, low digit first, segment bytes shift in from the top
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == CNT_W'(DIGITS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIGITS - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= value;
        end
        else if (busy_reg)
        begin
            n_reg   <= n_next;
            seg_reg <= {seg_code(rem_full[3:0]), seg_reg[SEGS_W-1:SEG_W]};
        end
    end

    assign done = done_reg;
    assign seg  = seg_reg;

endmodule

### rtl/queued_seven_segment_number_display.sv
// Queued six-digit display driver. Software writes land in a value queue held in a
// single-port-write RAM; a written zero clears stop and adds a start credit, values
// above 999999 are refused and a full queue drops the value. A display tick starts a
// run when a credit waits, pops one value per tick while the queue holds data and
// stop is clear, and otherwise ends the run and drops the credits. Items are taken
// one at a time: a new request is accepted only in the idle state, once the last
// result has entered the output register; a tick that pops first passes through the
// registered queue read and the six steps of the digit converter (one digit a cycle).
// A finished result waits in the output register while the next request is taken.
module queued_seven_segment_number_display #(
    parameter int QUEUE_DEPTH = 64,
    parameter int CREDIT_MAX  = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value[31:0], buttons[35:32], zero pad
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // status[2:0], seg_low[34:3], seg_high[50:35], pad
    output logic        m_axis_tuser    // display_valid
);
    import qssd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CR_W  = $clog2(CREDIT_MAX + 1);
    localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [CR_W-1:0]  CREDIT_TOP = CR_W'(CREDIT_MAX);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CONV,
        S_OUT
    } state_t;

    state_t             state_reg;
    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   tail_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               stop_reg;
    logic               run_reg;
    logic [CR_W-1:0]    credit_reg;
    status_t            pend_status_reg;
    logic               pend_shown_reg;
    logic               out_valid_reg;
    status_t            out_status_reg;
    logic               out_shown_reg;
    logic [31:0]        out_low_reg;
    logic [15:0]        out_high_reg;

    op_t                    op;
    logic [31:0]            value;
    logic [3:0]             buttons;
    logic                   accept;
    logic                   out_free;
    logic                   ram_we;
    logic                   ram_re;
    logic [VALUE_W-1:0]     ram_rdata;
    logic                   conv_done;
    logic [DIGITS*SEG_W-1:0] conv_seg;
    logic                   run_now;
    logic                   can_pop;

    assign op      = op_t'(s_axis_tuser);
    assign value   = s_axis_tdata[31:0];
    assign buttons = s_axis_tdata[35:32];
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    // queue write on an accepted value, read on a tick that pops
    always_comb
    begin
        run_now = run_reg || (credit_reg != '0);
        can_pop = run_now && (count_reg != '0) && !stop_reg;
        ram_we  = accept && (op == OP_WRITE) && (value != '0) && (value <= MAX_NUMBER)
                  && (count_reg != FULL_COUNT);
        ram_re  = accept && (op == OP_TICK) && can_pop;
    end

    qssd_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (value[VALUE_W-1:0]),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    qssd_conv u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_READ),
        .value (ram_rdata),
        .done  (conv_done),
        .seg   (conv_seg)
    );

    // request sequencing, queue pointers, flags and credits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            stop_reg        <= 1'b0;
            run_reg         <= 1'b0;
            credit_reg      <= '0;
            pend_status_reg <= ST_NONE;
            pend_shown_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= ST_NONE;
            out_shown_reg   <= 1'b0;
        end
        else
        begin
            // the output register reloads in S_OUT, so drain it elsewhere only
            if (out_valid_reg && m_axis_tready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (op)
                            OP_WRITE:
                            begin
                                pend_shown_reg <= 1'b0;
                                state_reg      <= S_OUT;
                                if (value == '0)
                                begin
                                    stop_reg <= 1'b0;
                                    if (credit_reg != CREDIT_TOP)
                                    begin
                                        credit_reg <= credit_reg + 1'b1;
                                    end
                                    pend_status_reg <= ST_ZERO;
                                end
                                else if (value > MAX_NUMBER)
                                begin
                                    pend_status_reg <= ST_TOO_LARGE;
                                end
                                else if (count_reg == FULL_COUNT)
                                begin
                                    pend_status_reg <= ST_FULL;
                                end
                                else
                                begin
                                    tail_reg  <= (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
                                    count_reg <= count_reg + 1'b1;
                                    pend_status_reg <= ST_QUEUED;
                                end
                            end
                            OP_BUTTON:
                            begin
                                pend_status_reg <= ST_NONE;
                                pend_shown_reg  <= 1'b0;
                                state_reg       <= S_OUT;
                                if (buttons[STOP_BIT])
                                begin
                                    stop_reg <= 1'b1;
                                end
                            end
                            OP_TICK:
                            begin
                                pend_status_reg <= ST_NONE;
                                if (can_pop)
                                begin
                                    if (!run_reg)
                                    begin
                                        credit_reg <= credit_reg - 1'b1;
                                    end
                                    run_reg   <= 1'b1;
                                    head_reg  <= (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
                                    count_reg <= count_reg - 1'b1;
                                    pend_shown_reg <= 1'b1;
                                    state_reg <= S_READ;
                                end
                                else
                                begin
                                    pend_shown_reg <= 1'b0;
                                    state_reg      <= S_OUT;
                                    if (run_now)
                                    begin
                                        run_reg    <= 1'b0;
                                        credit_reg <= '0;
                                    end
                                end
                            end
                            default:
                            begin
                                pend_status_reg <= ST_NONE;
                                pend_shown_reg  <= 1'b0;
                                state_reg       <= S_OUT;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    state_reg <= S_CONV;
                end
                S_CONV:
                begin
                    if (conv_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= pend_status_reg;
                        out_shown_reg  <= pend_shown_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // segment payload, zero when nothing is shown
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            out_low_reg  <= pend_shown_reg ? conv_seg[31:0] : '0;
            out_high_reg <= pend_shown_reg ? conv_seg[47:32] : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_shown_reg;
    assign m_axis_tdata  = {5'b0, out_high_reg, out_low_reg, out_status_reg};

endmodule

### rtl/qssd_check.sv
module qssd_check (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    import qssd_pkg::*;

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // nothing shown means blank segment words
    a_blank: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[50:3] == '0)
        else $error("segment words not blank without display");

    // a shown value comes only from a tick, never from a write
    a_tick: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[2:0] == ST_NONE)
        else $error("display on a write request");

    // the lowest and highest shown digits each light at least one segment
    a_lit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[10:3] != '0 &&
        m_axis_tdata[50:43] != '0)
        else $error("dark digit on a shown value");

endmodule

bind queued_seven_segment_number_display qssd_check u_qssd_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### test/qssd_checker.sv
module qssd_checker
    import qssd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int CREDIT_MAX  = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value[31:0], buttons[35:32], zero pad
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,   // status[2:0], seg_low[34:3], seg_high[50:35], pad
    input  logic        m_axis_tuser,   // display_valid
    output int          mismatches,
    output int          pending,
    output int          checked,
    output int          shown
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t     status;
        logic        show;
        logic [31:0] seg_low;
        logic [15:0] seg_high;
    } display_result_t;

    // segment byte per decimal digit, digit 0 in the low byte
    localparam logic [79:0] SEGMENT_TABLE = {
        8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    // shadow copy of the display state
    logic [VALUE_W-1:0] number_fifo [QUEUE_DEPTH];
    int                 fifo_head;
    int                 fifo_tail;
    int                 fifo_count;
    logic               stop_set;
    logic               run_on;
    int                 credits;

    display_result_t    expected_displays [$];

    initial begin
        mismatches = 0;
        pending    = 0;
        checked    = 0;
        shown      = 0;
    end

    // one request in, one expected result out
    function automatic display_result_t predict_display(input op_t op,
                                                        input logic [31:0] number,
                                                        input logic [3:0] edges);
        display_result_t r;
        logic [19:0]     n;
        logic [3:0]      digit;
        r = '{status: ST_NONE, show: 1'b0, seg_low: '0, seg_high: '0};
        case (op)
            OP_WRITE:
            begin
                if (number == 32'd0)
                begin
                    stop_set = 1'b0;
                    if (credits < CREDIT_MAX)
                        credits++;
                    r.status = ST_ZERO;
                end
                else if (number > MAX_NUMBER)
                    r.status = ST_TOO_LARGE;
                else if (fifo_count >= QUEUE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    number_fifo[fifo_tail] = number[19:0];
                    fifo_tail = (fifo_tail + 1 >= QUEUE_DEPTH) ? 0 : fifo_tail + 1;
                    fifo_count++;
                    r.status = ST_QUEUED;
                end
            end
            OP_BUTTON:
            begin
                if (edges[STOP_BIT])
                    stop_set = 1'b1;
            end
            OP_TICK:
            begin
                if (!run_on && credits > 0)
                begin
                    credits--;
                    run_on = 1'b1;
                end
                if (run_on)
                begin
                    if (fifo_count > 0 && !stop_set)
                    begin
                        n = number_fifo[fifo_head];
                        fifo_head = (fifo_head + 1 >= QUEUE_DEPTH) ? 0 : fifo_head + 1;
                        fifo_count--;
                        for (int d = 0; d < DIGITS; d++)
                        begin
                            digit = 4'(n % 20'd10);
                            n = n / 20'd10;
                            if (d < 4)
                                r.seg_low[d*8 +: 8] = SEGMENT_TABLE[digit*8 +: 8];
                            else
                                r.seg_high[(d-4)*8 +: 8] = SEGMENT_TABLE[digit*8 +: 8];
                        end
                        r.show = 1'b1;
                    end
                    else
                    begin
                        run_on  = 1'b0;
                        credits = 0;
                    end
                end
            end
            default:
            begin
                r.status = ST_NONE;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("ERROR result %0d %s: expected %0h, got %0h", checked, field, want, got);
        mismatches++;
    endtask

    // watch both channels, predict on request, compare on result
    always @(posedge clk or negedge rst_n)
    begin
        display_result_t want;
        status_t         got_status;
        if (!rst_n)
        begin
            fifo_head  = 0;
            fifo_tail  = 0;
            fifo_count = 0;
            stop_set   = 1'b0;
            run_on     = 1'b0;
            credits    = 0;
            expected_displays.delete();
            pending    = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_displays.push_back(predict_display(op_t'(s_axis_tuser),
                                                            s_axis_tdata[31:0],
                                                            s_axis_tdata[35:32]));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_displays.size() == 0)
                    report_mismatch("unexpected result", '0, m_axis_tdata[31:0]);
                else
                begin
                    want = expected_displays.pop_front();
                    got_status = status_t'(m_axis_tdata[2:0]);
                    if (got_status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(m_axis_tdata[2:0]));
                    if (m_axis_tuser !== want.show)
                        report_mismatch("display_valid", 32'(want.show), 32'(m_axis_tuser));
                    if (m_axis_tdata[34:3] !== want.seg_low)
                        report_mismatch("seg_low", want.seg_low, m_axis_tdata[34:3]);
                    if (m_axis_tdata[50:35] !== want.seg_high)
                        report_mismatch("seg_high", 32'(want.seg_high), 32'(m_axis_tdata[50:35]));
                    if (want.show)
                        shown++;
                    checked++;
                end
            end
            pending = expected_displays.size();
        end
    end

endmodule

### test/tb_top.sv
module tb_top;
    import qssd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 64;
    localparam int CREDIT_MAX  = 15;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 24;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = OP_WRITE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;

    int mismatches;
    int pending;
    int checked;
    int shown;
    int requests_sent = 0;
    int source_idle_pct = 0;
    int sink_idle_pct = 0;
    int cycle_count = 0;

    queued_seven_segment_number_display #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CREDIT_MAX  (CREDIT_MAX)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    qssd_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CREDIT_MAX  (CREDIT_MAX)
    ) display_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .pending       (pending),
        .checked       (checked),
        .shown         (shown)
    );

    // 8 ns clock
    always #4 clk = ~clk;

    // receiver stalls at random
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("queued_seven_segment_number_display test failed");
            $finish;
        end
    end

    // one request, with an optional idle gap ahead of it
    task automatic send_request(input op_t op, input logic [31:0] number,
                                input logic [3:0] edges);
        int gap;
        gap = ($urandom_range(99) < source_idle_pct) ? $urandom_range(1, 5) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0000, edges, number};
        do
            @(posedge clk);
        while (!s_axis_tready);
        requests_sent++;
    endtask

    function automatic logic [31:0] pick_number();
        logic [31:0] n;
        case ($urandom_range(9))
            0:       n = 32'd0;
            1:       n = MAX_NUMBER;
            2:       n = MAX_NUMBER + 32'($urandom_range(1, 1000));
            3:       n = $urandom;
            default: n = 32'($urandom_range(1, 999999));
        endcase
        return n;
    endfunction

    function automatic logic [31:0] in_range_number();
        return ($urandom_range(7) == 0) ? MAX_NUMBER : 32'($urandom_range(1, 999999));
    endfunction

    // one random sequence, often a well-formed load and show run
    task automatic random_sequence();
        int count;
        case ($urandom_range(11))
            0, 1, 2, 3, 4:
            begin
                // load a few numbers, start, then tick through them
                count = $urandom_range(1, 12);
                repeat (count) send_request(OP_WRITE, in_range_number(), 4'($urandom));
                send_request(OP_WRITE, 32'd0, 4'($urandom));
                repeat ($urandom_range(count, count + 3))
                    send_request(OP_TICK, $urandom, 4'($urandom));
            end
            5:
            begin
                // run the queue into full
                repeat (QUEUE_DEPTH + 3) send_request(OP_WRITE, in_range_number(), 4'h0);
            end
            6:
            begin
                // long drain
                send_request(OP_WRITE, 32'd0, 4'h0);
                repeat ($urandom_range(10, QUEUE_DEPTH + 4)) send_request(OP_TICK, 32'd0, 4'h0);
            end
            7:
            begin
                // pile up start credits up to and past saturation
                repeat ($urandom_range(CREDIT_MAX - 1, CREDIT_MAX + 3))
                    send_request(OP_WRITE, 32'd0, 4'h0);
                repeat ($urandom_range(1, 6)) send_request(OP_TICK, 32'd0, 4'h0);
            end
            8:
            begin
                // stop in the middle of a run
                send_request(OP_WRITE, 32'd0, 4'h0);
                repeat ($urandom_range(2, 6)) send_request(OP_WRITE, in_range_number(), 4'h0);
                send_request(OP_TICK, 32'd0, 4'h0);
                send_request(OP_BUTTON, $urandom, 4'($urandom) | 4'h1);
                repeat ($urandom_range(1, 3)) send_request(OP_TICK, 32'd0, 4'h0);
            end
            9:
            begin
                // noise, every op code
                repeat (8) send_request(op_t'($urandom_range(3)), $urandom, 4'($urandom));
            end
            10:
            begin
                repeat (6) send_request(OP_WRITE, pick_number(), 4'($urandom));
            end
            default:
            begin
                send_request(OP_BUTTON, $urandom, 4'($urandom));
                send_request(OP_UNUSED, $urandom, 4'($urandom));
                send_request(OP_TICK, $urandom, 4'($urandom));
            end
        endcase
    endtask

    initial
    begin
        source_idle_pct = 6;
        sink_idle_pct   = 60;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: op extremes, bounds, run start and end, stop cases
        send_request(OP_UNUSED, 32'hFFFF_FFFF, 4'hF);
        send_request(OP_TICK, 32'd0, 4'h0);
        send_request(OP_WRITE, MAX_NUMBER, 4'h0);
        send_request(OP_WRITE, MAX_NUMBER + 32'd1, 4'h0);
        send_request(OP_WRITE, 32'hFFFF_FFFF, 4'hF);
        send_request(OP_WRITE, 32'd1, 4'h0);
        send_request(OP_WRITE, 32'd123456, 4'h0);
        send_request(OP_WRITE, 32'd0, 4'h0);
        send_request(OP_BUTTON, 32'hFFFF_FFFF, 4'hE);
        repeat (4) send_request(OP_TICK, 32'd0, 4'h0);
        send_request(OP_WRITE, 32'd0, 4'h0);
        send_request(OP_WRITE, 32'd987654, 4'h0);
        send_request(OP_BUTTON, 32'd0, 4'h1);
        send_request(OP_TICK, 32'd0, 4'h0);
        send_request(OP_WRITE, 32'd0, 4'h0);
        send_request(OP_TICK, 32'hFFFF_FFFF, 4'hF);
        send_request(OP_TICK, 32'd0, 4'h0);

        // sender rarely idle, receiver often stalled
        while (requests_sent < 340)
            random_sequence();

        // sender often idle, receiver rarely stalled
        source_idle_pct = 60;
        sink_idle_pct   = 6;
        while (requests_sent < 680)
            random_sequence();

        // full rate both ways
        source_idle_pct = 0;
        sink_idle_pct   = 0;
        while (requests_sent < 1020)
            random_sequence();

        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("sent %0d requests, checked %0d results, %0d numbers shown",
                 requests_sent, checked, shown);
        $display("covered receiver-side stalls, sender-side gaps and back-to-back traffic");
        if (mismatches == 0)
            $display("queued_seven_segment_number_display test passed");
        else
            $display("queued_seven_segment_number_display test failed");
        $finish;
    end

endmodule

### queued_seven_segment_number_display.f
rtl/qssd_pkg.sv
rtl/qssd_ram.sv
rtl/qssd_conv.sv
rtl/queued_seven_segment_number_display.sv
rtl/qssd_check.sv
test/qssd_checker.sv
test/tb_top.sv
